// File: sv/cssm_pkg.sv
package cssm_pkg;

   localparam int MAX_ROWS_A_DEF = 8;
   localparam int MAX_ROWS_B_DEF = 8;
   localparam int MAX_DIM_DEF    = 128;

   // Quotient bits produced by the divider (Q1.15, including the integer bit).
   localparam int QUOT_BITS = 16;

   localparam logic [1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROWS_A = 2'd0;
   localparam logic [1:0] CSR_ROWS_B = 2'd1;
   localparam logic [1:0] CSR_VLEN   = 2'd2;

   localparam logic [3:0] ROWS_RESET = 4'd8;
   localparam logic [7:0] VLEN_RESET = 8'd128;

endpackage

// File: sv/cssm_ram.sv
module cssm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/cssm_isqrt.sv
module cssm_isqrt #(
   parameter int NW = 54,
   localparam int RW = NW / 2,
   localparam int CW = $clog2(NW / 2 + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] value,
   output logic          done,
   output logic [RW-1:0] root
);

   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] res_ff, res_in;
   logic [NW-1:0] bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [NW-1:0] trial;

   // One result bit per cycle, digit-by-digit square root.
   always_comb begin
      trial   = res_ff + bit_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         n_in   = value;
         res_in = '0;
         bit_in = NW'(1) << (NW - 2);
         cnt_in = CW'(NW / 2);
      end else if (cnt_ff != '0) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[RW-1:0];

endmodule

// File: sv/cssm_div.sv
module cssm_div
   import cssm_pkg::*;
#(
   parameter int MW = 40,
   parameter int DW = 54,
   localparam int RW = DW + 1,
   localparam int CW = $clog2(QUOT_BITS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MW-1:0]        mag,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic [QUOT_BITS-1:0] quot
);

   logic [RW-1:0]        r_ff, r_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DW-1:0]        den_ff;
   logic [RW-1:0]        shifted;

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // mag * 2^15 < den, so the quotient fits in QUOT_BITS.
   always_comb begin
      shifted = {r_ff[RW-2:0], 1'b0};
      r_in    = r_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         r_in   = RW'({mag, 15'b0});
         q_in   = '0;
         cnt_in = CW'(QUOT_BITS);
      end else if (cnt_ff != '0) begin
         if (shifted >= RW'(den_ff)) begin
            r_in = shifted - RW'(den_ff);
            q_in = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      r_ff <= r_in;
      q_ff <= q_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: sv/cosine_similarity_matrix_unit.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   kind, row, column, element
// rsp       out        rsp_valid/rsp_stall   a_row, b_row, similarity, last
// csr       in         csr_valid/csr_ready   index, data
//
// Loads are accepted back to back while the unit is idle.
// A compute request holds req_stall high until its last result is registered.
// Each row pair runs accumulate, square root and, unless skipped, the divider; the root
// width RW is 27 at the default MAX_DIM. A result waits in the result register while
// rsp_stall is high.
// Reset is synchronous; the stores are not cleared, csr_ready is always high.
module cosine_similarity_matrix_unit
   import cssm_pkg::*;
#(
   parameter int MAX_ROWS_A = MAX_ROWS_A_DEF,
   parameter int MAX_ROWS_B = MAX_ROWS_B_DEF,
   parameter int MAX_DIM    = MAX_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_row,
   input  logic [6:0]         req_column,
   input  logic signed [15:0] req_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_a_row,
   output logic [2:0]         rsp_b_row,
   output logic signed [15:0] rsp_similarity,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);

   localparam int DEPTH_A = MAX_ROWS_A * MAX_DIM;
   localparam int DEPTH_B = MAX_ROWS_B * MAX_DIM;
   localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
   localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
   localparam int IW_A    = (MAX_ROWS_A > 1) ? $clog2(MAX_ROWS_A) : 1;
   localparam int IW_B    = (MAX_ROWS_B > 1) ? $clog2(MAX_ROWS_B) : 1;
   localparam int DCW     = $clog2(MAX_DIM + 1);
   localparam int LOGD    = $clog2(MAX_DIM);
   localparam int DOTW    = 33 + LOGD;
   localparam int SSW     = 31 + LOGD;
   localparam int NW      = ((SSW + 17) / 2) * 2;
   localparam int RTW     = NW / 2;
   localparam int DW      = 2 * RTW;
   localparam int CMPW    = DOTW + DW + 18;
   localparam int QW      = QUOT_BITS + 1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ACC  = 7'b0000010,
      ST_SQRT = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_CHK  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type st_ff, st_in;

   logic [3:0] rows_a_ff, rows_b_ff;
   logic [7:0] vlen_ff;

   logic [IW_A-1:0] i_ff, i_in, a_last_idx;
   logic [IW_B-1:0] j_ff, j_in, b_last_idx;
   logic [DCW-1:0]  d_ff, d_in, len_c;

   logic                   rd_v_ff, pr_v_ff;
   logic signed [31:0]     pab_ff;
   logic [30:0]            paa_ff, pbb_ff;
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic [SSW-1:0]         ssa_ff, ssa_in, ssb_ff, ssb_in;
   logic [DW-1:0]          den_ff;
   logic [DOTW-1:0]        mag_ff;
   logic                   neg_ff;
   logic [QW-1:0]          qv_ff, qv_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_a_row_ff, rsp_b_row_ff;
   logic [15:0] rsp_sim_ff;
   logic        rsp_last_ff;

   logic [11:0] vlen_wide, vlen_sel;
   logic [3:0]  ra_sel, rb_sel;

   logic        req_acc, wr_a, wr_b, col_ok;
   logic [31:0] waddr_full, raddr_a_full, raddr_b_full;
   logic [15:0] rdata_a, rdata_b;
   logic        issue, acc_done, sq_start, sq_done_a, sq_done_b;
   logic [RTW-1:0] root_a, root_b;
   logic        div_start, div_done, sat, slot_free, out_load, pair_last;
   logic [QUOT_BITS-1:0] div_q;
   logic [QW-1:0] q_neg_lim, q_pos_lim;
   logic [15:0] sim_val;

   // Register values are clamped into their legal ranges where they are used.
   always_comb begin
      vlen_wide = {4'b0, vlen_ff};
      if (vlen_wide == 12'd0) begin
         vlen_sel = 12'd1;
      end else if (vlen_wide > 12'(MAX_DIM)) begin
         vlen_sel = 12'(MAX_DIM);
      end else begin
         vlen_sel = vlen_wide;
      end
      if (rows_a_ff == 4'd0) begin
         ra_sel = 4'd0;
      end else if (rows_a_ff > 4'(MAX_ROWS_A)) begin
         ra_sel = 4'(MAX_ROWS_A - 1);
      end else begin
         ra_sel = rows_a_ff - 4'd1;
      end
      if (rows_b_ff == 4'd0) begin
         rb_sel = 4'd0;
      end else if (rows_b_ff > 4'(MAX_ROWS_B)) begin
         rb_sel = 4'(MAX_ROWS_B - 1);
      end else begin
         rb_sel = rows_b_ff - 4'd1;
      end
   end

   assign len_c      = vlen_sel[DCW-1:0];
   assign a_last_idx = ra_sel[IW_A-1:0];
   assign b_last_idx = rb_sel[IW_B-1:0];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= ROWS_RESET;
         rows_b_ff <= ROWS_RESET;
         vlen_ff   <= VLEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_A: rows_a_ff <= csr_data[3:0];
            CSR_ROWS_B: rows_b_ff <= csr_data[3:0];
            CSR_VLEN:   vlen_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Loads are taken only in idle, so they never overlap compute reads.
   assign req_stall  = (st_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign col_ok     = ({5'b0, req_column} < 12'(MAX_DIM));
   assign wr_a       = req_acc && (req_kind == KIND_LOAD_A) && col_ok
                       && ({1'b0, req_row} < 4'(MAX_ROWS_A));
   assign wr_b       = req_acc && (req_kind == KIND_LOAD_B) && col_ok
                       && ({1'b0, req_row} < 4'(MAX_ROWS_B));
   assign waddr_full   = 32'(req_row) * 32'(MAX_DIM) + 32'(req_column);
   assign raddr_a_full = 32'(i_ff) * 32'(MAX_DIM) + 32'(d_ff);
   assign raddr_b_full = 32'(j_ff) * 32'(MAX_DIM) + 32'(d_ff);

   cssm_ram #(.WIDTH(16), .DEPTH(DEPTH_A)) u_store_a (
      .clock (clock),
      .we    (wr_a),
      .waddr (waddr_full[AW_A-1:0]),
      .wdata (req_element),
      .raddr (raddr_a_full[AW_A-1:0]),
      .rdata (rdata_a)
   );

   cssm_ram #(.WIDTH(16), .DEPTH(DEPTH_B)) u_store_b (
      .clock (clock),
      .we    (wr_b),
      .waddr (waddr_full[AW_B-1:0]),
      .wdata (req_element),
      .raddr (raddr_b_full[AW_B-1:0]),
      .rdata (rdata_b)
   );

   assign issue    = (st_ff == ST_ACC) && (d_ff < len_c);
   assign acc_done = (st_ff == ST_ACC) && !issue && !rd_v_ff && !pr_v_ff;
   assign sq_start = acc_done;

   cssm_isqrt #(.NW(NW)) u_sqrt_a (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (NW'({ssa_ff, 16'b0})),
      .done  (sq_done_a),
      .root  (root_a)
   );

   cssm_isqrt #(.NW(NW)) u_sqrt_b (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (NW'({ssb_ff, 16'b0})),
      .done  (sq_done_b),
      .root  (root_b)
   );

   // A quotient of two or more saturates, so the divider only sees
   // mag * 2^16 < 2 * den.
   assign sat = (CMPW'({mag_ff, 16'b0}) >= CMPW'({den_ff, 1'b0}));
   assign div_start = (st_ff == ST_CHK) && (den_ff != '0) && !sat;

   cssm_div #(.MW(DOTW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (mag_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (st_ff == ST_OUT) && slot_free;
   assign pair_last = (i_ff == a_last_idx) && (j_ff == b_last_idx);

   always_comb begin
      q_neg_lim = (qv_ff > QW'(32768)) ? QW'(32768) : qv_ff;
      q_pos_lim = (qv_ff > QW'(32767)) ? QW'(32767) : qv_ff;
      if (neg_ff) begin
         sim_val = 16'(QW'(0) - q_neg_lim);
      end else begin
         sim_val = q_pos_lim[15:0];
      end
   end

   always_comb begin
      st_in  = st_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      d_in   = d_ff;
      qv_in  = qv_ff;
      dot_in = dot_ff;
      ssa_in = ssa_ff;
      ssb_in = ssb_ff;
      if (pr_v_ff) begin
         dot_in = dot_ff + DOTW'(pab_ff);
         ssa_in = ssa_ff + SSW'(paa_ff);
         ssb_in = ssb_ff + SSW'(pbb_ff);
      end
      case (st_ff)
         ST_IDLE: begin
            if (req_acc && (req_kind == KIND_COMPUTE)) begin
               i_in   = '0;
               j_in   = '0;
               d_in   = '0;
               dot_in = '0;
               ssa_in = '0;
               ssb_in = '0;
               st_in  = ST_ACC;
            end
         end
         ST_ACC: begin
            if (issue) begin
               d_in = d_ff + DCW'(1);
            end
            if (acc_done) begin
               st_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done_a) begin
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            st_in = ST_CHK;
         end
         ST_CHK: begin
            if (den_ff == '0) begin
               qv_in = '0;
               st_in = ST_OUT;
            end else if (sat) begin
               qv_in = QW'(65536);
               st_in = ST_OUT;
            end else begin
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               qv_in = QW'(div_q);
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               d_in   = '0;
               dot_in = '0;
               ssa_in = '0;
               ssb_in = '0;
               if (pair_last) begin
                  st_in = ST_IDLE;
               end else begin
                  st_in = ST_ACC;
                  if (j_ff == b_last_idx) begin
                     j_in = '0;
                     i_in = i_ff + IW_A'(1);
                  end else begin
                     j_in = j_ff + IW_B'(1);
                  end
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         pr_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rd_v_ff <= issue;
         pr_v_ff <= rd_v_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      d_ff   <= d_in;
      qv_ff  <= qv_in;
      dot_ff <= dot_in;
      ssa_ff <= ssa_in;
      ssb_ff <= ssb_in;
      pab_ff <= 32'($signed(rdata_a)) * 32'($signed(rdata_b));
      paa_ff <= 31'(32'($signed(rdata_a)) * 32'($signed(rdata_a)));
      pbb_ff <= 31'(32'($signed(rdata_b)) * 32'($signed(rdata_b)));
      if (st_ff == ST_MUL) begin
         den_ff <= DW'(root_a) * DW'(root_b);
         neg_ff <= dot_ff[DOTW-1];
         mag_ff <= dot_ff[DOTW-1] ? DOTW'(-dot_ff) : DOTW'(dot_ff);
      end
      if (out_load) begin
         rsp_a_row_ff <= 3'(i_ff);
         rsp_b_row_ff <= 3'(j_ff);
         rsp_sim_ff   <= sim_val;
         rsp_last_ff  <= pair_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_a_row      = rsp_a_row_ff;
   assign rsp_b_row      = rsp_b_row_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_last       = rsp_last_ff;

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (wr_a || wr_b) |-> (st_ff == ST_IDLE))
      else $error("store written during compute");

   a_sqrt_lockstep: assert property (@(posedge clock) disable iff (reset)
      sq_done_a == sq_done_b)
      else $error("square root units out of step");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (den_ff != '0) && !sat)
      else $error("divider started out of range");

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_sim_ff))
      else $error("pending result overwritten");

endmodule
